// ===== design/grs_pkg.sv =====
// ============================================================================
// Group reverse stream package
// Shared types and constants for the group reverse stream block.
// ============================================================================
`timescale 1ns / 1ps

package grs_pkg;

    // Width of the group size configuration register.
    localparam int CFG_W = 5;

    // Group size after reset.
    localparam logic [CFG_W-1:0] GROUP_SIZE_RESET = 5'd2;

    // One list element, two's complement.
    typedef logic signed [31:0] t_value;

    // Group size register contents.
    typedef logic [CFG_W-1:0] t_group_size;

endpackage

// ===== design/grs_in_if.sv =====
// ============================================================================
// Group reverse stream input channel
// Valid/ready channel that carries one list element per word.
// ============================================================================
`timescale 1ns / 1ps

interface grs_in_if
    import grs_pkg::*;
();
    logic   valid;
    logic   ready;
    t_value value;
    logic   list_last;

    modport source (output valid, output value, output list_last, input ready);
    modport sink   (input valid, input value, input list_last, output ready);
endinterface

// ===== design/grs_out_if.sv =====
// ============================================================================
// Group reverse stream output channel
// Valid/ready channel that carries one reordered element per word.
// ============================================================================
`timescale 1ns / 1ps

interface grs_out_if
    import grs_pkg::*;
();
    logic   valid;
    logic   ready;
    t_value out_value;
    logic   run_last;
    logic   list_end;

    modport source (output valid, output out_value, output run_last, output list_end,
                    input ready);
    modport sink   (input valid, input out_value, input run_last, input list_end,
                    output ready);
endinterface

// ===== design/group_reverse_stream.sv =====
// ============================================================================
// Group reverse stream
// Buffers list elements in a small memory and emits each full group newest
// first, and a short final group in arrival order.
// ============================================================================
// The input word that completes a group or ends the list moves the
// controller to the drain state; the first word of the run is then read
// into the registered output word, and later words follow one per cycle
// while the output is taken. Input is not accepted while a run drains; the
// single memory read port yields the buffered elements of the run in turn.
// Reset is synchronous and active low: it clears the state, the fill count
// and the output valid, and sets the group size to 2. The buffer memory is
// not cleared; an entry is always written before it is read.
`timescale 1ns / 1ps

module group_reverse_stream
    import grs_pkg::*;
#(
    parameter int MAX_GROUP = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  t_group_size     i_cfg_wdata,
    grs_in_if.sink          i_in,
    grs_out_if.source       o_out
);

    // Fill counts run from 0 to MAX_GROUP; addresses from 0 to MAX_GROUP-1.
    localparam int CNT_W = $clog2(MAX_GROUP + 1);
    localparam int AW    = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
    // Comparison width that holds both a count and the configured size.
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    // Controller states: taking input words, or draining a run.
    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    t_group_size        r_group_size;
    logic               r_state,     n_state;
    logic [CNT_W-1:0]   r_fill,      n_fill;
    logic [AW-1:0]      r_addr,      n_addr;
    logic [CNT_W-1:0]   r_left,      n_left;
    logic               r_rev,       n_rev;
    logic               r_last,      n_last;
    logic               r_out_valid, n_out_valid;
    t_value             r_rdata;
    logic               r_run_last;
    logic               r_list_end;

    // The group buffer: one write port during input, one read port while
    // draining. Read data lands in r_rdata, which is also the output word.
    t_value             r_mem [MAX_GROUP];

    // ------------------------------------------------------------------
    // Combinational control
    // ------------------------------------------------------------------
    logic               in_accept;
    logic               wr_en;
    logic               rd_en;
    logic [CNT_W-1:0]   cnt_after;
    logic [CMP_W-1:0]   size_ext;
    logic [CMP_W-1:0]   eff_size;
    logic               group_full;
    logic               final_step;

    assign in_accept = i_in.valid && i_in.ready;

    // The element is stored only while the buffer has room. With the size
    // clamped to MAX_GROUP a group always empties before the buffer fills.
    assign wr_en     = in_accept && (r_fill < CNT_W'(MAX_GROUP));
    assign cnt_after = wr_en ? (r_fill + CNT_W'(1)) : r_fill;

    // A size of zero behaves as one, and a size above the buffer depth
    // behaves as the depth.
    assign size_ext = CMP_W'(r_group_size);
    always_comb begin
        if (size_ext == '0) begin
            eff_size = CMP_W'(1);
        end else if (size_ext > CMP_W'(MAX_GROUP)) begin
            eff_size = CMP_W'(MAX_GROUP);
        end else begin
            eff_size = size_ext;
        end
    end

    // The buffer holds a complete group once the count reaches the size.
    // This also covers the size being lowered below the current count.
    assign group_full = (CMP_W'(cnt_after) >= eff_size);

    // In the drain state a new memory read is issued whenever the output word is
    // free or is being taken in this cycle, so a run drains at one word per cycle while the output is taken.
    assign rd_en      = (r_state == ST_DRAIN) && (!r_out_valid || o_out.ready);
    assign final_step = (r_left == CNT_W'(1));

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_addr      = r_addr;
        n_left      = r_left;
        n_rev       = r_rev;
        n_last      = r_last;
        n_out_valid = r_out_valid;

        if (o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    if (group_full || i_in.list_last) begin
                        // Start a run: newest first for a full group, arrival
                        // order for a short group closing the list.
                        n_state = ST_DRAIN;
                        n_fill  = '0;
                        n_left  = cnt_after;
                        n_rev   = group_full;
                        n_last  = i_in.list_last;
                        n_addr  = group_full ? AW'(cnt_after - CNT_W'(1)) : '0;
                    end else begin
                        n_fill  = cnt_after;
                    end
                end
            end
            ST_DRAIN: begin
                if (rd_en) begin
                    n_out_valid = 1'b1;
                    n_left      = r_left - CNT_W'(1);
                    n_addr      = r_rev ? (r_addr - AW'(1)) : (r_addr + AW'(1));
                    if (final_step) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_size <= GROUP_SIZE_RESET;
            r_state      <= ST_IDLE;
            r_fill       <= '0;
            r_addr       <= '0;
            r_left       <= '0;
            r_rev        <= 1'b0;
            r_last       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_group_size <= i_cfg_wdata;
            end
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_addr      <= n_addr;
            r_left      <= n_left;
            r_rev       <= n_rev;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
        end
    end

    // ------------------------------------------------------------------
    // Buffer memory. Writes happen only while idle and reads only while
    // draining, so the two ports never touch the same entry in one cycle.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_fill[AW-1:0]] <= i_in.value;
        end
    end

    // Registered read port; the flags of the word travel with its data.
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata    <= r_mem[r_addr];
            r_run_last <= final_step;
            r_list_end <= final_step && r_last;
        end
    end

    // ------------------------------------------------------------------
    // Ports
    // ------------------------------------------------------------------
    assign i_in.ready      = (r_state == ST_IDLE);
    assign o_out.valid     = r_out_valid;
    assign o_out.out_value = r_rdata;
    assign o_out.run_last  = r_run_last;
    assign o_out.list_end  = r_list_end;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // A run always has at least one word left while draining.
    a_drain_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAIN) |-> (r_left != '0))
        else $error("drain state with no words left");

    // The buffer never holds a whole buffer's worth between runs.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_fill < CNT_W'(MAX_GROUP)))
        else $error("fill count reached buffer depth while idle");

    // The end of a list always clears the fill count.
    a_list_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_in.list_last) |=> (r_fill == '0) && (r_state == ST_DRAIN))
        else $error("list end did not start a run and clear the buffer");

    // The final read of a run is flagged run_last and returns to idle; list_end falls only there.
    a_end_on_run_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rd_en && final_step) |=> (r_out_valid && r_run_last && (r_state == ST_IDLE)))
        else $error("final read of a run not marked as run end");

endmodule
